/* sv/plle_pkg.sv */
// shared types and constants for the pooled linked list engine
`default_nettype none

package plle_pkg;

    localparam int DATA_W = 32;

    // configuration register index (paddr bit 2)
    localparam logic REG_HEAD_VALUE = 1'b0;

    typedef enum logic {
        CMD_INSERT = 1'b0,
        CMD_DELETE = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_POOL_FULL = 2'd2,
        ST_NO_NEXT   = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_WALK,
        S_INS_Q,
        S_DEL_Q,
        S_FIX_P,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        RD_NONE,
        RD_ZERO,
        RD_LINK,
        RD_FREE
    } t_rd_sel;

    typedef enum logic [2:0] {
        WR_NONE,
        WR_CLEAR,
        WR_INS_Q,
        WR_DEL_Q,
        WR_P
    } t_wr_sel;

    typedef struct packed {
        logic                      cmd;
        logic signed [DATA_W-1:0]  search_key;
        logic signed [DATA_W-1:0]  new_value;
    } t_in_word;

    typedef struct packed {
        logic [1:0]                status;
        logic signed [DATA_W-1:0]  removed_value;
    } t_out_word;

    typedef struct packed {
        logic     accept;
        logic     clr_step;
        t_rd_sel  rd_sel;
        t_wr_sel  wr_sel;
        logic     walk_step;
        logic     match_save;
        logic     set_status;
        t_status  status;
        logic     load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic clr_last;
        logic match;
        logic link_null;
        logic free_null;
        logic is_delete;
        logic out_busy;
    } t_dp_sts;

endpackage

`default_nettype wire

/* sv/plle_ram.sv */
// generic single write port ram with registered read
`default_nettype none

module plle_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_we,
    input  wire logic [$clog2(DEPTH)-1:0]  i_waddr,
    input  wire logic [WIDTH-1:0]          i_wdata,
    input  wire logic                      i_re,
    input  wire logic [$clog2(DEPTH)-1:0]  i_raddr,
    output logic      [WIDTH-1:0]          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

/* sv/plle_ctrl.sv */
// command sequencer for list walk, insert, delete and clearing pass
`default_nettype none

module plle_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire plle_pkg::t_dp_sts  i_sts,
    output plle_pkg::t_dp_cmd       o_cmd
);

    plle_pkg::t_state r_state;
    plle_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= plle_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            plle_pkg::S_CLEAR: begin
                if (i_sts.clr_last) n_state = plle_pkg::S_IDLE;
            end
            plle_pkg::S_IDLE: begin
                if (i_in_valid) n_state = plle_pkg::S_WALK;
            end
            plle_pkg::S_WALK: begin
                if (i_sts.match) begin
                    if (i_sts.is_delete) begin
                        n_state = i_sts.link_null ? plle_pkg::S_DONE : plle_pkg::S_DEL_Q;
                    end else begin
                        n_state = i_sts.free_null ? plle_pkg::S_DONE : plle_pkg::S_INS_Q;
                    end
                end else if (i_sts.link_null) begin
                    n_state = plle_pkg::S_DONE;
                end
            end
            plle_pkg::S_INS_Q: n_state = plle_pkg::S_FIX_P;
            plle_pkg::S_DEL_Q: n_state = plle_pkg::S_FIX_P;
            plle_pkg::S_FIX_P: n_state = plle_pkg::S_DONE;
            plle_pkg::S_DONE: begin
                if (!i_sts.out_busy) n_state = plle_pkg::S_IDLE;
            end
            default: n_state = plle_pkg::S_CLEAR;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            plle_pkg::S_CLEAR: begin
                o_cmd.wr_sel   = plle_pkg::WR_CLEAR;
                o_cmd.clr_step = 1'b1;
            end
            plle_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    o_cmd.rd_sel = plle_pkg::RD_ZERO;
                end
            end
            plle_pkg::S_WALK: begin
                if (i_sts.match) begin
                    o_cmd.match_save = 1'b1;
                    if (i_sts.is_delete) begin
                        if (i_sts.link_null) begin
                            o_cmd.set_status = 1'b1;
                            o_cmd.status     = plle_pkg::ST_NO_NEXT;
                        end else begin
                            o_cmd.rd_sel = plle_pkg::RD_LINK;
                        end
                    end else begin
                        if (i_sts.free_null) begin
                            o_cmd.set_status = 1'b1;
                            o_cmd.status     = plle_pkg::ST_POOL_FULL;
                        end else begin
                            o_cmd.rd_sel = plle_pkg::RD_FREE;
                        end
                    end
                end else if (i_sts.link_null) begin
                    o_cmd.set_status = 1'b1;
                    o_cmd.status     = plle_pkg::ST_NOT_FOUND;
                end else begin
                    o_cmd.rd_sel    = plle_pkg::RD_LINK;
                    o_cmd.walk_step = 1'b1;
                end
            end
            plle_pkg::S_INS_Q: o_cmd.wr_sel = plle_pkg::WR_INS_Q;
            plle_pkg::S_DEL_Q: o_cmd.wr_sel = plle_pkg::WR_DEL_Q;
            plle_pkg::S_FIX_P: begin
                o_cmd.wr_sel     = plle_pkg::WR_P;
                o_cmd.set_status = 1'b1;
                o_cmd.status     = plle_pkg::ST_OK;
            end
            plle_pkg::S_DONE: begin
                if (!i_sts.out_busy) o_cmd.load_out = 1'b1;
            end
            default: o_cmd = '0;
        endcase
    end

endmodule

`default_nettype wire

/* sv/plle_dp.sv */
// node pool, free list head, walk pointers and result register
`default_nettype none

module plle_dp #(
    parameter int POOL_DEPTH = 512
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire plle_pkg::t_dp_cmd                  i_cmd,
    output plle_pkg::t_dp_sts                       o_sts,
    input  wire plle_pkg::t_in_word                 i_in_word,
    input  wire logic signed [plle_pkg::DATA_W-1:0] i_head_value,
    input  wire logic                               i_out_ready,
    output logic                                    o_out_valid,
    output plle_pkg::t_out_word                     o_out_word
);

    localparam int AW = $clog2(POOL_DEPTH);
    localparam int LW = $clog2(POOL_DEPTH + 1);
    localparam int NW = plle_pkg::DATA_W + LW;
    localparam logic [LW-1:0] LINK_NULL = LW'(POOL_DEPTH);
    localparam logic [AW-1:0] LAST_SLOT = AW'(POOL_DEPTH - 1);

    logic                               r_cmd,     n_cmd;
    logic signed [plle_pkg::DATA_W-1:0] r_key,     n_key;
    logic signed [plle_pkg::DATA_W-1:0] r_new,     n_new;
    logic [AW-1:0]                      r_cur,     n_cur;
    logic [AW-1:0]                      r_p,       n_p;
    logic [LW-1:0]                      r_plink,   n_plink;
    logic [LW-1:0]                      r_pnew,    n_pnew;
    logic [LW-1:0]                      r_free,    n_free;
    logic [AW-1:0]                      r_clr,     n_clr;
    logic [1:0]                         r_status,  n_status;
    logic signed [plle_pkg::DATA_W-1:0] r_removed, n_removed;
    logic                               r_out_valid, n_out_valid;
    plle_pkg::t_out_word                r_out_word,  n_out_word;

    logic [NW-1:0]                      w_rdata;
    logic signed [plle_pkg::DATA_W-1:0] w_rd_value;
    logic [LW-1:0]                      w_rd_link;
    logic                               w_re;
    logic [AW-1:0]                      w_raddr;
    logic                               w_we;
    logic [AW-1:0]                      w_waddr;
    logic [NW-1:0]                      w_wdata;
    logic [LW-1:0]                      w_clr_link;
    logic signed [plle_pkg::DATA_W-1:0] w_cur_value;

    assign w_rd_value = w_rdata[NW-1:LW];
    assign w_rd_link  = w_rdata[LW-1:0];

    // head slot value lives in the config register, not in the pool
    assign w_cur_value = (r_cur == '0) ? i_head_value : w_rd_value;

    assign w_clr_link = (r_clr == '0 || r_clr == LAST_SLOT) ? LINK_NULL
                                                            : LW'(r_clr) + LW'(1);

    // read port select
    always_comb begin
        w_re    = 1'b1;
        w_raddr = '0;
        case (i_cmd.rd_sel)
            plle_pkg::RD_ZERO: w_raddr = '0;
            plle_pkg::RD_LINK: w_raddr = w_rd_link[AW-1:0];
            plle_pkg::RD_FREE: w_raddr = r_free[AW-1:0];
            default:           w_re    = 1'b0;
        endcase
    end

    // write port select
    always_comb begin
        w_we    = 1'b1;
        w_waddr = '0;
        w_wdata = '0;
        case (i_cmd.wr_sel)
            plle_pkg::WR_CLEAR: begin
                w_waddr = r_clr;
                w_wdata = {{plle_pkg::DATA_W{1'b0}}, w_clr_link};
            end
            plle_pkg::WR_INS_Q: begin
                w_waddr = r_free[AW-1:0];
                w_wdata = {r_new, r_plink};
            end
            plle_pkg::WR_DEL_Q: begin
                w_waddr = r_plink[AW-1:0];
                w_wdata = {w_rd_value, r_free};
            end
            plle_pkg::WR_P: begin
                // p matched the key, so its value field is rewritten unchanged
                w_waddr = r_p;
                w_wdata = {r_key, r_pnew};
            end
            default: w_we = 1'b0;
        endcase
    end

    plle_ram #(
        .WIDTH (NW),
        .DEPTH (POOL_DEPTH)
    ) u_node_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    always_comb begin
        n_cmd       = r_cmd;
        n_key       = r_key;
        n_new       = r_new;
        n_cur       = r_cur;
        n_p         = r_p;
        n_plink     = r_plink;
        n_pnew      = r_pnew;
        n_free      = r_free;
        n_clr       = r_clr;
        n_status    = r_status;
        n_removed   = r_removed;
        n_out_word  = r_out_word;
        n_out_valid = r_out_valid;

        if (i_cmd.clr_step) n_clr = r_clr + AW'(1);
        if (i_cmd.accept) begin
            n_cmd     = i_in_word.cmd;
            n_key     = i_in_word.search_key;
            n_new     = i_in_word.new_value;
            n_cur     = '0;
            n_removed = '0;
        end
        if (i_cmd.walk_step) n_cur = w_rd_link[AW-1:0];
        if (i_cmd.match_save) begin
            n_p     = r_cur;
            n_plink = w_rd_link;
        end
        case (i_cmd.wr_sel)
            plle_pkg::WR_INS_Q: begin
                n_free = w_rd_link;
                n_pnew = r_free;
            end
            plle_pkg::WR_DEL_Q: begin
                n_free    = r_plink;
                n_pnew    = w_rd_link;
                n_removed = w_rd_value;
            end
            default: ;
        endcase
        if (i_cmd.set_status) n_status = i_cmd.status;

        if (i_cmd.load_out) begin
            n_out_valid = 1'b1;
            n_out_word  = '{status: r_status, removed_value: r_removed};
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free      <= LW'(1);
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_free      <= n_free;
            r_clr       <= n_clr;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_key      <= n_key;
        r_new      <= n_new;
        r_cur      <= n_cur;
        r_p        <= n_p;
        r_plink    <= n_plink;
        r_pnew     <= n_pnew;
        r_status   <= n_status;
        r_removed  <= n_removed;
        r_out_word <= n_out_word;
    end

    assign o_sts.clr_last  = (r_clr == LAST_SLOT);
    assign o_sts.match     = (w_cur_value == r_key);
    assign o_sts.link_null = (w_rd_link >= LINK_NULL);
    assign o_sts.free_null = (r_free >= LINK_NULL);
    assign o_sts.is_delete = (r_cmd == plle_pkg::CMD_DELETE);
    assign o_sts.out_busy  = r_out_valid && !i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

`default_nettype wire

/* sv/pooled_linked_list_engine.sv */
// top level of the pooled linked list engine: config register, sequencer and datapath
`default_nettype none

//  channel   direction  handshake                        payload
//  in        in         i_in_valid / o_in_ready          i_in_word  (t_in_word)
//  out       out        o_out_valid / i_out_ready        o_out_word (t_out_word)
//  config    in         psel, penable, pwrite, pready    paddr, pwdata / prdata
//
//  a word passes an accept step, a walk step for each list node visited up to the
//  match (at most POOL_DEPTH nodes), the pool update steps (new or removed node,
//  then p) when the status is ok and none on a failing status, and a result step
//  the walk is bound by the single read port of the node ram, one link per read
//  after reset a clearing pass writes the link of every slot with o_in_ready
//  low; the config port is served as usual
//  the result register lets a new word be accepted while a result waits;
//  a finished command holds in its result step until the result register frees

module pooled_linked_list_engine #(
    parameter int POOL_DEPTH = 512
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // command words
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire plle_pkg::t_in_word   i_in_word,
    // result words
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output plle_pkg::t_out_word       o_out_word,
    // config port
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [2:0]           paddr,
    input  wire logic [31:0]          pwdata,
    output logic [31:0]               prdata,
    output logic                      pready
);

    logic signed [plle_pkg::DATA_W-1:0] r_head_value;
    logic signed [plle_pkg::DATA_W-1:0] n_head_value;
    logic                               w_cfg_wr;
    logic                               w_head_sel;

    plle_pkg::t_dp_cmd w_dp_cmd;
    plle_pkg::t_dp_sts w_dp_sts;

    // config port: pready always high, one register at word 0
    assign pready     = 1'b1;
    assign w_head_sel = (paddr[2] == plle_pkg::REG_HEAD_VALUE);
    assign w_cfg_wr   = psel && penable && pwrite && pready;

    always_comb begin
        n_head_value = r_head_value;
        if (w_cfg_wr && w_head_sel) n_head_value = pwdata;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head_value <= '0;
        end else begin
            r_head_value <= n_head_value;
        end
    end

    // addresses past the register list read as zero
    assign prdata = w_head_sel ? r_head_value : 32'd0;

    // sequencer: clearing pass, walk, pool update, result hand-off
    plle_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (w_dp_sts),
        .o_cmd      (w_dp_cmd)
    );

    // node pool with value and link per slot, free list head, result register
    plle_dp #(
        .POOL_DEPTH (POOL_DEPTH)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_dp_cmd),
        .o_sts        (w_dp_sts),
        .i_in_word    (i_in_word),
        .i_head_value (r_head_value),
        .i_out_ready  (i_out_ready),
        .o_out_valid  (o_out_valid),
        .o_out_word   (o_out_word)
    );

    // no pool write while the block offers to take a command
    a_no_write_when_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> (w_dp_cmd.wr_sel == plle_pkg::WR_NONE))
        else $error("pool written while ready for a command");

    // a result cannot be produced in the cycle right after an accept
    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !w_dp_cmd.load_out)
        else $error("result loaded right after accept");

    // the result register is never overwritten while a result waits
    a_no_result_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_dp_cmd.load_out |-> !(o_out_valid && !i_out_ready))
        else $error("result register overrun");

    // a removed value only comes with an ok status
    a_removed_only_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_word.removed_value != '0))
            |-> (o_out_word.status == plle_pkg::ST_OK))
        else $error("removed value with a failing status");

endmodule

`default_nettype wire
